// ===== rtl/atw_pkg.sv =====
// ----------------------------------------------------------------------------
// atw_pkg
// Types and constants shared by the text terminal writer: request payloads,
// control-sequence byte codes, colour defaults and the sequencer states.
// ----------------------------------------------------------------------------
package atw_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } atw_in_t;

  typedef struct packed {
    logic [15:0] cell_code;
    logic [7:0]  cell_fg;
    logic [7:0]  cell_bg;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        cursor_shown;
  } atw_out_t;

  // Parser phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  // Stream bytes.
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] FIN_SGR    = 8'h6D;
  localparam logic [7:0] FIN_CUP    = 8'h48;
  localparam logic [7:0] FIN_EL     = 8'h4B;
  localparam logic [7:0] FIN_ED     = 8'h4A;
  localparam logic [7:0] FIN_CUB    = 8'h44;
  localparam logic [7:0] FIN_CUF    = 8'h43;
  localparam logic [7:0] FIN_SHOW   = 8'h68;

  // Code points with a control meaning.
  localparam logic [15:0] CP_CR    = 16'h000D;
  localparam logic [15:0] CP_LF    = 16'h000A;
  localparam logic [15:0] CP_BS    = 16'h0008;
  localparam logic [15:0] CP_DEL   = 16'h007F;
  localparam logic [15:0] CP_SPACE = 16'h0020;

  // SGR parameter values.
  localparam logic [15:0] SGR_RESET  = 16'd0;
  localparam logic [15:0] SGR_FG_DEF = 16'd39;
  localparam logic [15:0] SGR_BG_DEF = 16'd49;
  localparam logic [15:0] SGR_FG_EXT = 16'd38;
  localparam logic [15:0] SGR_BG_EXT = 16'd48;
  localparam logic [15:0] SGR_IDX    = 16'd5;
  localparam logic [15:0] SGR_RGB    = 16'd2;

  localparam logic [7:0] DEFAULT_FG = 8'd15;

  typedef enum logic [9:0] {
    ST_INIT   = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_READ   = 10'b0000000100,
    ST_SCROLL = 10'b0000001000,
    ST_DRAIN  = 10'b0000010000,
    ST_PUT    = 10'b0000100000,
    ST_ERASE  = 10'b0001000000,
    ST_EL     = 10'b0010000000,
    ST_SGR    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } atw_state_t;

  // Decimal digit accumulation, saturating at the 16-bit maximum.
  function automatic logic [15:0] num_push(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] r;
    r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'h0000, d};
    return (r > 20'h0FFFF) ? 16'hFFFF : r[15:0];
  endfunction

endpackage

// ===== rtl/ansi_text_terminal_writer.sv =====
// A line feed on the bottom row scrolls the cell memory one cell a cycle, and a character
// that forced the wrap is written after the scroll; an erase-line clears from the cursor to the
// end of the row, an erase-display the whole memory. An SGR takes one attribute step at a time,
// at most MAX_PARAMS steps. One request is worked on at a time.
// After reset a clearing pass over the cell memory runs before the first request is taken.
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer
// Text terminal core: decodes UTF-8 (up to three bytes) and ESC[ control
// sequences from a byte stream, writes coloured cells into an on-chip cell
// memory, and reads cells back.
module ansi_text_terminal_writer #(
  parameter int ROWS       = 26,
  parameter int COLS       = 80,
  parameter int MAX_PARAMS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  atw_pkg::atw_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output atw_pkg::atw_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import atw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLS + 1);
  localparam int PCW   = $clog2(MAX_PARAMS + 1);
  localparam int PIW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0] MOVE_LEN  = AW'(CELLS - COLS);

  // The cell memory: code in the low half, foreground and background above it.
  logic [31:0] mem [CELLS];
  logic [31:0] mem_q_r;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  atw_state_t st_r, st_nxt;

  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [7:0]     fore_r, fore_nxt, back_r, back_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic           priv_r, priv_nxt;
  logic [15:0]    last_r, last_nxt, prior_r, prior_nxt;
  logic [15:0]    plist_r [MAX_PARAMS];
  logic [15:0]    plist_nxt [MAX_PARAMS];
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [PCW-1:0] sgr_rem_r, sgr_rem_nxt;
  logic [1:0]     utf_rem_r, utf_rem_nxt;
  logic [15:0]    utf_part_r, utf_part_nxt;
  logic           cur_on_r, cur_on_nxt;

  // Sweep pointer, shared by the clearing, erase and scroll passes, and the erase-line end.
  logic [AW-1:0]  sc_r, sc_nxt, sweep_end_r, sweep_end_nxt;
  // Read-modify-write stage: the write lands in the cycle after its read.
  logic           pw_valid_r, pw_valid_nxt;
  logic [AW-1:0]  pw_addr_r, pw_addr_nxt;
  logic           pw_zcode_r, pw_zcode_nxt;
  // A character that waits for a scroll to finish.
  logic           put_pend_r, put_pend_nxt;
  logic [15:0]    put_code_r, put_code_nxt;
  // Cell fields of the result and whether the read address was on the screen.
  logic [15:0]    res_code_r, res_code_nxt;
  logic [7:0]     res_fg_r, res_fg_nxt, res_bg_r, res_bg_nxt;
  logic           rd_ok_r, rd_ok_nxt;

  logic           out_valid_r;
  atw_out_t       out_r;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * COLS + 32'(c));
  endfunction

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] part_new, cp, rtmp, ctmp, step, v, p1, p2;
    logic [16:0] csum;
    logic        put_req;
    logic [15:0] win [MAX_PARAMS + 5];
    logic [2:0]  shamt;
    logic [PIW-1:0] pidx;

    st_nxt        = st_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    fore_nxt      = fore_r;
    back_nxt      = back_r;
    phase_nxt     = phase_r;
    priv_nxt      = priv_r;
    last_nxt      = last_r;
    prior_nxt     = prior_r;
    plist_nxt     = plist_r;
    pcnt_nxt      = pcnt_r;
    sgr_rem_nxt   = sgr_rem_r;
    utf_rem_nxt   = utf_rem_r;
    utf_part_nxt  = utf_part_r;
    cur_on_nxt    = cur_on_r;
    sc_nxt        = sc_r;
    sweep_end_nxt = sweep_end_r;
    pw_valid_nxt  = 1'b0;
    pw_addr_nxt   = pw_addr_r;
    pw_zcode_nxt  = pw_zcode_r;
    put_pend_nxt  = put_pend_r;
    put_code_nxt  = put_code_r;
    res_code_nxt  = res_code_r;
    res_fg_nxt    = res_fg_r;
    res_bg_nxt    = res_bg_r;
    rd_ok_nxt     = rd_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    b         = in_data.data_byte;
    part_new  = {utf_part_r[9:0], b[5:0]};
    cp        = (utf_rem_r != 2'd0) ? part_new : {8'h00, b};
    put_req   = (phase_r != PH_ESC) && (phase_r != PH_CSI) && (b != ESC_BYTE) &&
                ((utf_rem_r == 2'd1) || ((utf_rem_r == 2'd0) && !b[7]));
    rtmp      = (prior_r == 16'd0) ? 16'd0 : prior_r - 16'd1;
    ctmp      = (last_r == 16'd0) ? 16'd0 : last_r - 16'd1;
    step      = (last_r == 16'd0) ? 16'd1 : last_r;
    csum      = 17'(col_r) + 17'(step);
    pidx      = pcnt_r[PIW-1:0];
    shamt     = 3'd1;
    for (int j = 0; j < MAX_PARAMS + 5; j++) begin
      win[j] = (j < MAX_PARAMS) ? plist_r[j] : 16'd0;
    end
    v  = win[0];
    p1 = win[1];
    p2 = win[2];

    // The read-modify-write stage owns the write port whenever it holds a write.
    if (pw_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = pw_addr_r;
      mem_wdata = pw_zcode_r ? {mem_q_r[31:16], 16'h0000} : mem_q_r;
    end

    case (st_r)
      ST_INIT, ST_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = sc_r;
        mem_wdata = '0;
        sc_nxt    = sc_r + AW'(1);
        if (sc_r == LAST_ADDR) begin
          st_nxt = (st_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt       = ST_DONE;
          res_code_nxt = '0;
          res_fg_nxt   = '0;
          res_bg_nxt   = '0;
          if (in_data.func) begin
            rd_ok_nxt = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLS);
            if (rd_ok_nxt) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(32'(in_data.read_row) * COLS + 32'(in_data.read_col));
            end
            st_nxt = ST_READ;
          end else begin
            case (phase_r)
              PH_ESC: begin
                if (b == CH_LBRACK) begin
                  phase_nxt = PH_CSI;
                  priv_nxt  = 1'b0;
                  last_nxt  = '0;
                  prior_nxt = '0;
                  pcnt_nxt  = '0;
                  for (int j = 0; j < MAX_PARAMS; j++) plist_nxt[j] = '0;
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end
              PH_CSI: begin
                if (b == CH_QMARK) begin
                  priv_nxt = 1'b1;
                end else if (b inside {[CH_ZERO:CH_NINE]}) begin
                  if (!priv_r) last_nxt = num_push(last_r, b[3:0]);
                  if (32'(pcnt_r) < MAX_PARAMS) begin
                    plist_nxt[pidx] = num_push(plist_r[pidx], b[3:0]);
                  end
                end else if (b == CH_SEMI) begin
                  prior_nxt = priv_r ? 16'd0 : last_r;
                  priv_nxt  = 1'b0;
                  last_nxt  = '0;
                  if (32'(pcnt_r) < MAX_PARAMS) pcnt_nxt = pcnt_r + PCW'(1);
                end else begin
                  phase_nxt = PH_IDLE;
                  if (b == FIN_SGR) begin
                    sgr_rem_nxt = (32'(pcnt_r) + 1 > MAX_PARAMS) ? PCW'(MAX_PARAMS)
                                                                 : pcnt_r + PCW'(1);
                    pcnt_nxt    = '0;
                    st_nxt      = ST_SGR;
                  end else if (priv_r) begin
                    cur_on_nxt = (b == FIN_SHOW);
                  end else if (b == FIN_CUP) begin
                    row_nxt = (32'(rtmp) >= ROWS) ? RW'(ROWS - 1) : RW'(rtmp);
                    col_nxt = (32'(ctmp) >= COLS) ? CW'(COLS - 1) : CW'(ctmp);
                  end else if (b == FIN_EL) begin
                    if (32'(col_r) < COLS) begin
                      sc_nxt        = cell_addr(row_r, col_r);
                      sweep_end_nxt = cell_addr(row_r, CW'(COLS - 1));
                      st_nxt        = ST_EL;
                    end
                  end else if (b == FIN_ED) begin
                    sc_nxt  = '0;
                    row_nxt = '0;
                    col_nxt = '0;
                    st_nxt  = ST_ERASE;
                  end else if (b == FIN_CUB) begin
                    col_nxt = (32'(step) >= 32'(col_r)) ? '0 : col_r - CW'(step);
                  end else if (b == FIN_CUF) begin
                    col_nxt = (32'(csum) >= COLS) ? CW'(COLS - 1) : CW'(csum);
                  end
                end
              end
              default: begin
                if (b == ESC_BYTE) begin
                  utf_rem_nxt = 2'd0;
                  phase_nxt   = PH_ESC;
                end else if (utf_rem_r != 2'd0) begin
                  utf_part_nxt = part_new;
                  utf_rem_nxt  = utf_rem_r - 2'd1;
                end else if (b inside {[8'hC0:8'hDF]}) begin
                  utf_rem_nxt  = 2'd1;
                  utf_part_nxt = {11'd0, b[4:0]};
                end else if (b inside {[8'hE0:8'hEF]}) begin
                  utf_rem_nxt  = 2'd2;
                  utf_part_nxt = {12'd0, b[3:0]};
                end
                if (put_req) begin
                  if (cp == CP_CR) begin
                    col_nxt = '0;
                  end else if (cp == CP_LF) begin
                    col_nxt = '0;
                    if (32'(row_r) < ROWS - 1) begin
                      row_nxt = row_r + RW'(1);
                    end else begin
                      sc_nxt       = '0;
                      put_pend_nxt = 1'b0;
                      st_nxt       = ST_SCROLL;
                    end
                  end else if (cp == CP_BS) begin
                    if (col_r != '0) begin
                      col_nxt      = col_r - CW'(1);
                      mem_re       = 1'b1;
                      mem_raddr    = cell_addr(row_r, col_r - CW'(1));
                      pw_valid_nxt = 1'b1;
                      pw_addr_nxt  = mem_raddr;
                      pw_zcode_nxt = 1'b1;
                      st_nxt       = ST_DRAIN;
                    end
                  end else if ((cp >= CP_SPACE) && (cp != CP_DEL)) begin
                    if (32'(col_r) >= COLS) begin
                      if (32'(row_r) < ROWS - 1) begin
                        row_nxt   = row_r + RW'(1);
                        col_nxt   = CW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(row_r + RW'(1), '0);
                        mem_wdata = {back_r, fore_r, cp};
                      end else begin
                        col_nxt      = '0;
                        sc_nxt       = '0;
                        put_pend_nxt = 1'b1;
                        put_code_nxt = cp;
                        st_nxt       = ST_SCROLL;
                      end
                    end else begin
                      col_nxt   = col_r + CW'(1);
                      mem_we    = 1'b1;
                      mem_waddr = cell_addr(row_r, col_r);
                      mem_wdata = {back_r, fore_r, cp};
                    end
                  end
                end
              end
            endcase
          end
        end
      end
      ST_READ: begin
        res_code_nxt = rd_ok_r ? mem_q_r[15:0]  : 16'd0;
        res_fg_nxt   = rd_ok_r ? mem_q_r[23:16] : 8'd0;
        res_bg_nxt   = rd_ok_r ? mem_q_r[31:24] : 8'd0;
        st_nxt       = ST_DONE;
      end
      ST_SCROLL: begin
        mem_re       = 1'b1;
        mem_raddr    = (sc_r < MOVE_LEN) ? sc_r + AW'(COLS) : sc_r;
        pw_valid_nxt = 1'b1;
        pw_addr_nxt  = sc_r;
        pw_zcode_nxt = (sc_r >= MOVE_LEN);
        sc_nxt       = sc_r + AW'(1);
        if (sc_r == LAST_ADDR) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        st_nxt = put_pend_r ? ST_PUT : ST_DONE;
      end
      ST_PUT: begin
        mem_we       = 1'b1;
        mem_waddr    = cell_addr(row_r, col_r);
        mem_wdata    = {back_r, fore_r, put_code_r};
        col_nxt      = col_r + CW'(1);
        put_pend_nxt = 1'b0;
        st_nxt       = ST_DONE;
      end
      ST_EL: begin
        mem_we    = 1'b1;
        mem_waddr = sc_r;
        mem_wdata = '0;
        sc_nxt    = sc_r + AW'(1);
        if (sc_r == sweep_end_r) st_nxt = ST_DONE;
      end
      ST_SGR: begin
        if (sgr_rem_r == '0) begin
          st_nxt = ST_DONE;
        end else begin
          if (v == SGR_RESET) begin
            fore_nxt = DEFAULT_FG;
            back_nxt = 8'd0;
          end else if (v == SGR_FG_DEF) begin
            fore_nxt = DEFAULT_FG;
          end else if (v == SGR_BG_DEF) begin
            back_nxt = 8'd0;
          end else if ((v == SGR_FG_EXT) || (v == SGR_BG_EXT)) begin
            if ((32'(sgr_rem_r) >= 3) && (p1 == SGR_IDX)) begin
              if (v == SGR_FG_EXT) fore_nxt = (p2 > 16'd255) ? 8'hFF : p2[7:0];
              else                 back_nxt = (p2 > 16'd255) ? 8'hFF : p2[7:0];
              shamt = 3'd3;
            end else if ((32'(sgr_rem_r) >= 5) && (p1 == SGR_RGB)) begin
              shamt = 3'd5;
            end
          end
          sgr_rem_nxt = sgr_rem_r - PCW'(shamt);
          // Move the parameter window on past every parameter this step used.
          for (int j = 0; j < MAX_PARAMS; j++) begin
            plist_nxt[j] = (shamt == 3'd5) ? win[j + 5] :
                           (shamt == 3'd3) ? win[j + 3] : win[j + 1];
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Loading the foreground register takes effect at once.
    if (cfg_valid) fore_nxt = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_INIT;
      row_r      <= '0;
      col_r      <= '0;
      fore_r     <= DEFAULT_FG;
      back_r     <= '0;
      phase_r    <= PH_IDLE;
      priv_r     <= 1'b0;
      last_r     <= '0;
      prior_r    <= '0;
      for (int j = 0; j < MAX_PARAMS; j++) plist_r[j] <= '0;
      pcnt_r     <= '0;
      sgr_rem_r  <= '0;
      utf_rem_r  <= '0;
      utf_part_r <= '0;
      cur_on_r   <= 1'b1;
      sc_r       <= '0;
      pw_valid_r <= 1'b0;
      put_pend_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fore_r     <= fore_nxt;
      back_r     <= back_nxt;
      phase_r    <= phase_nxt;
      priv_r     <= priv_nxt;
      last_r     <= last_nxt;
      prior_r    <= prior_nxt;
      plist_r    <= plist_nxt;
      pcnt_r     <= pcnt_nxt;
      sgr_rem_r  <= sgr_rem_nxt;
      utf_rem_r  <= utf_rem_nxt;
      utf_part_r <= utf_part_nxt;
      cur_on_r   <= cur_on_nxt;
      sc_r       <= sc_nxt;
      pw_valid_r <= pw_valid_nxt;
      put_pend_r <= put_pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sweep_end_r <= sweep_end_nxt;
    pw_addr_r   <= pw_addr_nxt;
    pw_zcode_r  <= pw_zcode_nxt;
    put_code_r  <= put_code_nxt;
    res_code_r  <= res_code_nxt;
    res_fg_r    <= res_fg_nxt;
    res_bg_r    <= res_bg_nxt;
    rd_ok_r     <= rd_ok_nxt;
  end

  // Result register: it parts the sequencer from the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_r.cell_code    <= res_code_r;
      out_r.cell_fg      <= res_fg_r;
      out_r.cell_bg      <= res_bg_r;
      out_r.cursor_row   <= 5'(row_r);
      out_r.cursor_col   <= 7'(col_r);
      out_r.cursor_shown <= cur_on_r;
    end
  end

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("sequencer state is not one-hot");

  // A pending read-modify-write only exists while scrolling or draining.
  a_pw_owner: assert property (@(posedge clk) disable iff (!rst_n)
    pw_valid_r |-> (st_r == ST_SCROLL) || (st_r == ST_DRAIN))
    else $error("read-modify-write outside scroll or drain");

  // Every accepted request leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r != ST_IDLE))
    else $error("request accepted without leaving idle");

  // The cursor never leaves the screen (column COLS marks a pending wrap).
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < ROWS) && (32'(col_r) <= COLS))
    else $error("cursor out of range");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text terminal writer testbench
// Drives byte and cell-read requests into the terminal core, keeps a
// behavioural copy of the screen, parser and cursor, and compares every
// result field by field in arrival order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import atw_pkg::*;

  localparam int NROWS = 26;
  localparam int NCOLS = 80;
  localparam int NPAR  = 8;
  localparam logic FN_BYTE = 1'b0;
  localparam logic FN_READ = 1'b1;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  atw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  atw_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  always #1 clk = ~clk;

  ansi_text_terminal_writer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Screen model: code in bits 15:0, foreground 23:16, background 31:24.
  logic [31:0] screen [NROWS*NCOLS];
  int unsigned cur_row, cur_col, fg_idx, bg_idx;
  int unsigned phase, last_num, prev_num, npar, utf_left, utf_acc;
  int unsigned params [NPAR];
  bit priv, shown;

  atw_out_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic int unsigned push_digit(int unsigned v, int unsigned d);
    int unsigned r;
    r = v * 10 + d;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic void model_reset();
    foreach (screen[i]) screen[i] = '0;
    cur_row = 0; cur_col = 0; fg_idx = DEFAULT_FG; bg_idx = 0;
    phase = PH_IDLE; priv = 0; last_num = 0; prev_num = 0; npar = 0;
    foreach (params[i]) params[i] = 0;
    utf_left = 0; utf_acc = 0; shown = 1;
  endfunction

  function automatic void new_line();
    if (cur_row < NROWS - 1) cur_row++;
    else begin
      for (int i = 0; i < (NROWS-1)*NCOLS; i++) screen[i] = screen[i+NCOLS];
      for (int c = 0; c < NCOLS; c++) screen[(NROWS-1)*NCOLS+c][15:0] = '0;
    end
    cur_col = 0;
  endfunction

  function automatic void draw(int unsigned cp);
    if (cp == CP_CR) cur_col = 0;
    else if (cp == CP_LF) new_line();
    else if (cp == CP_BS) begin
      if (cur_col > 0) begin
        cur_col--;
        screen[cur_row*NCOLS+cur_col][15:0] = '0;
      end
    end else if (cp >= CP_SPACE && cp != CP_DEL) begin
      if (cur_col >= NCOLS) new_line();
      screen[cur_row*NCOLS+cur_col] = {bg_idx[7:0], fg_idx[7:0], cp[15:0]};
      cur_col++;
    end
  endfunction

  function automatic void attributes();
    int unsigned n, v, ix;
    n = (npar + 1 > NPAR) ? NPAR : npar + 1;
    for (int unsigned i = 0; i < n; i++) begin
      v = params[i];
      if (v == SGR_RESET) begin fg_idx = DEFAULT_FG; bg_idx = 0; end
      else if (v == SGR_FG_DEF) fg_idx = DEFAULT_FG;
      else if (v == SGR_BG_DEF) bg_idx = 0;
      else if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
        if (i + 2 < n && params[i+1] == SGR_IDX) begin
          ix = (params[i+2] > 255) ? 255 : params[i+2];
          if (v == SGR_FG_EXT) fg_idx = ix; else bg_idx = ix;
          i += 2;
        end else if (i + 4 < n && params[i+1] == SGR_RGB) i += 4;
      end
    end
  endfunction

  function automatic void end_sequence(logic [7:0] b);
    int unsigned k;
    phase = PH_IDLE;
    if (b == FIN_SGR) begin attributes(); npar = 0; end
    else if (priv) shown = (b == FIN_SHOW);
    else if (b == FIN_CUP) begin
      cur_row = (prev_num > 0) ? prev_num - 1 : 0;
      cur_col = (last_num > 0) ? last_num - 1 : 0;
      if (cur_row >= NROWS) cur_row = NROWS - 1;
      if (cur_col >= NCOLS) cur_col = NCOLS - 1;
    end else if (b == FIN_EL) begin
      for (int unsigned c = cur_col; c < NCOLS; c++) screen[cur_row*NCOLS+c] = '0;
    end else if (b == FIN_ED) begin
      foreach (screen[i]) screen[i] = '0;
      cur_row = 0; cur_col = 0;
    end else if (b == FIN_CUB) begin
      k = (last_num > 0) ? last_num : 1;
      cur_col = (k >= cur_col) ? 0 : cur_col - k;
    end else if (b == FIN_CUF) begin
      cur_col += (last_num > 0) ? last_num : 1;
      if (cur_col >= NCOLS) cur_col = NCOLS - 1;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (phase == PH_ESC) begin
      if (b == CH_LBRACK) begin
        phase = PH_CSI; priv = 0; last_num = 0; prev_num = 0; npar = 0;
        foreach (params[i]) params[i] = 0;
      end else phase = PH_IDLE;
    end else if (phase == PH_CSI) begin
      if (b == CH_QMARK) priv = 1;
      else if (b >= CH_ZERO && b <= CH_NINE) begin
        if (!priv) last_num = push_digit(last_num, b - CH_ZERO);
        if (npar < NPAR) params[npar] = push_digit(params[npar], b - CH_ZERO);
      end else if (b == CH_SEMI) begin
        prev_num = priv ? 0 : last_num;
        priv = 0; last_num = 0;
        if (npar < NPAR) npar++;
      end else end_sequence(b);
    end else if (b == ESC_BYTE) begin
      utf_left = 0; phase = PH_ESC;
    end else if (utf_left > 0) begin
      utf_acc = ((utf_acc << 6) | (b & 8'h3F)) & 16'hFFFF;
      utf_left--;
      if (utf_left == 0) draw(utf_acc);
    end else if (b < 8'h80) draw(b);
    else if (b >= 8'hC0 && b < 8'hE0) begin utf_left = 1; utf_acc = b & 8'h1F; end
    else if (b >= 8'hE0 && b < 8'hF0) begin utf_left = 2; utf_acc = b & 8'h0F; end
  endfunction

  function automatic atw_out_t terminal_result(atw_in_t req);
    atw_out_t r;
    logic [31:0] v;
    r = '0;
    if (req.func == FN_BYTE) take_byte(req.data_byte);
    else if (req.read_row < NROWS && req.read_col < NCOLS) begin
      v = screen[req.read_row*NCOLS+req.read_col];
      r.cell_code = v[15:0]; r.cell_fg = v[23:16]; r.cell_bg = v[31:24];
    end
    r.cursor_row = cur_row[4:0];
    r.cursor_col = cur_col[6:0];
    r.cursor_shown = shown;
    return r;
  endfunction

  // Sends one request, with a random gap first unless in a calm stretch.
  // Valid stays high between back-to-back requests and drops only in a gap or a drain.
  task automatic send(input atw_in_t req);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(terminal_result(req));
  endtask

  task automatic put_byte(input logic [7:0] b);
    atw_in_t req;
    req = '0;
    req.func = FN_BYTE; req.data_byte = b;
    req.read_row = 5'($urandom); req.read_col = 7'($urandom);
    send(req);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic read_cell(input int r, input int c);
    atw_in_t req;
    req = '0;
    req.func = FN_READ; req.data_byte = 8'($urandom);
    req.read_row = 5'(r); req.read_col = 7'(c);
    send(req);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (NROWS*NCOLS + 20) @(posedge clk);
  endtask

  task automatic write_start_fg(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fg_idx = v;
  endtask

  // Result checker: the receiver stalls at random unless in a calm stretch.
  always @(posedge clk) begin
    atw_out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) report("unexpected result", 0, 0);
      else begin
        want = expected_q.pop_front();
        if (out_data.cell_code != want.cell_code)
          report("cell_code", out_data.cell_code, want.cell_code);
        if (out_data.cell_fg != want.cell_fg) report("cell_fg", out_data.cell_fg, want.cell_fg);
        if (out_data.cell_bg != want.cell_bg) report("cell_bg", out_data.cell_bg, want.cell_bg);
        if (out_data.cursor_row != want.cursor_row)
          report("cursor_row", out_data.cursor_row, want.cursor_row);
        if (out_data.cursor_col != want.cursor_col)
          report("cursor_col", out_data.cursor_col, want.cursor_col);
        if (out_data.cursor_shown != want.cursor_shown)
          report("cursor_shown", out_data.cursor_shown, want.cursor_shown);
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 11);
  end

  // Extremes of the fields, UTF-8, controls, SGR colours and cursor show/hide sequences.
  task automatic test_directed();
    put_text("Hi");
    put_byte(8'hC3); put_byte(8'hA9);
    put_byte(8'hE2); put_byte(8'h82); put_byte(8'hAC);
    put_byte(8'hF0); put_byte(8'h80); put_byte(8'hFF);
    put_byte(8'h08); put_byte(8'h7F); put_byte(8'h01); put_byte(8'h00);
    read_cell(0, 0); read_cell(0, 2); read_cell(31, 127); read_cell(25, 79);
    put_text("\033[38;5;300;48;5;7mX\033[?25l\033[?1;25h");
    read_cell(0, 3);
  endtask

  task automatic test_cursor_edit();
    put_text("\033[99999;99999H\033[0;0H\033[5C\033[2D\033[0D\033[200C");
    put_text("AB\033[1;70HwrapXY\r\033[K\033[3J");
    put_text("\033[26;1H\n\n\033[x\033Zq\033[38;2;1;2;3;4;5;6;7;8;9;10m");
    read_cell(24, 0);
  endtask

  // Weighted random stream: mostly well-formed sequences with random content.
  task automatic test_random(input int count);
    int k;
    string s;
    for (int n = 0; n < count; ) begin
      k = $urandom_range(99);
      if (k < 30) begin put_byte(8'(8'h20 + $urandom_range(94))); n++; end
      else if (k < 38) begin read_cell($urandom_range(31), $urandom_range(127)); n++; end
      else if (k < 45) begin read_cell($urandom_range(NROWS-1), $urandom_range(NCOLS-1)); n++; end
      else if (k < 55) begin
        s = $sformatf("\033[%0d;%0dH", $urandom_range(30), $urandom_range(90));
        put_text(s); n += s.len();
      end else if (k < 65) begin
        s = $sformatf("\033[%0d;5;%0d;%0d;5;%0dm", ($urandom_range(1)) ? 38 : 48,
                      $urandom_range(300), ($urandom_range(1)) ? 38 : 48,
                      $urandom_range(255));
        put_text(s); n += s.len();
      end else if (k < 70) begin
        s = ($urandom_range(1)) ? "\033[0m" : "\033[39;49m";
        put_text(s); n += s.len();
      end else if (k < 75) begin
        s = $sformatf("\033[%0d%s", $urandom_range(12), ($urandom_range(1)) ? "C" : "D");
        put_text(s); n += s.len();
      end else if (k < 79) begin put_text("\033[K"); n += 3; end
      else if (k < 80) begin put_text("\033[2J"); n += 4; end
      else if (k < 85) begin put_byte(($urandom_range(2) == 0) ? 8'h08 :
                                      ($urandom_range(1) ? 8'h0A : 8'h0D)); n++; end
      else if (k < 90) begin
        put_byte(8'(8'hC0 + $urandom_range(47))); put_byte(8'($urandom)); n += 2;
      end else if (k < 93) begin
        s = ($urandom_range(1)) ? "\033[?25h" : "\033[?7l";
        put_text(s); n += s.len();
      end else begin put_byte(8'($urandom)); n++; end
    end
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_cursor_edit();
    write_start_fg(8'd0);
    put_text("\033[39mZ");
    write_start_fg(8'd255);
    put_text("Q\033[0m");
    test_random(700);
    // Pause the sender until the core has emptied its pipeline.
    drain();
    write_start_fg(8'($urandom));
    calm = 1'b1;
    test_random(300);
    calm = 1'b0;
    test_random(700);
    drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/atw_pkg.sv
rtl/ansi_text_terminal_writer.sv
tb/sv/tb.sv
